FILE: rtl/mep_pkg.sv
// Shared types, constants and a saturating helper function for the escape-time pixel block.
`default_nettype none

package mep_pkg;

  localparam int unsigned COORD_W   = 32;
  localparam int unsigned STEP_W    = 31;
  localparam int unsigned INDEX_W   = 12;
  localparam int unsigned ITER_W    = 16;
  localparam int unsigned SHIFT_W   = 8;
  localparam int unsigned PAL_W     = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned FRAC_BITS = 28;

  // Palette size; kept a power of two so the modulo is a mask.
  localparam int unsigned PALETTE_ENTRIES = 16;

  // Squared magnitude at which a point has escaped: 4.0 in unsigned Q8.28.
  localparam logic [35:0] ESCAPE_LIMIT = 36'(64'd4 << FRAC_BITS);

  // Reset values of the configuration registers.
  localparam logic [COORD_W-1:0] LEFT_RESET  = 32'hE000_0000;
  localparam logic [COORD_W-1:0] TOP_RESET   = 32'h1000_0000;
  localparam logic [STEP_W-1:0]  STEP_RESET  = 31'd262144;
  localparam logic [ITER_W-1:0]  ITER_RESET  = 16'd256;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 8'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT_EDGE   = 3'd0,
    CFG_TOP_EDGE    = 3'd1,
    CFG_COLUMN_STEP = 3'd2,
    CFG_ROW_STEP    = 3'd3,
    CFG_MAX_ITER    = 3'd4,
    CFG_PAL_SHIFT   = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COORD,
    ST_SQUARE,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic coord;
    logic square;
    logic update;
    logic publish;
  } dp_cmd_t;

  typedef struct packed {
    logic finish;
    logic out_free;
  } dp_status_t;

  // Clamp a 45-bit two's complement value to the signed 32-bit range.
  function automatic logic [COORD_W-1:0] sat32(input logic [44:0] v);
    logic [COORD_W-1:0] r;
    r = v[31:0];
    if (!v[44] && (|v[43:31])) begin
      r = 32'h7FFF_FFFF;
    end else if (v[44] && !(&v[43:31])) begin
      r = 32'h8000_0000;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/mep_pixel_if.sv
// Pixel request channel: row and column of one pixel.
`default_nettype none

interface mep_pixel_if;
  import mep_pkg::*;

  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] row;
  logic [INDEX_W-1:0] column;

  modport source (output valid, output row, output column, input ready);
  modport sink (input valid, input row, input column, output ready);
endinterface

`default_nettype wire

FILE: rtl/mep_result_if.sv
// Result channel: set membership, palette index and iteration count.
`default_nettype none

interface mep_result_if;
  import mep_pkg::*;

  logic              valid;
  logic              ready;
  logic              in_set;
  logic [PAL_W-1:0]  palette_index;
  logic [ITER_W-1:0] iterations;

  modport source (output valid, output in_set, output palette_index, output iterations,
                  input ready);
  modport sink (input valid, input in_set, input palette_index, input iterations,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/mep_cfg_if.sv
// Configuration write channel: register index and write data.
`default_nettype none

interface mep_cfg_if;
  import mep_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COORD_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/mep_ctrl.sv
// Controller state machine sequencing coordinate setup, iteration and result hand-off.
`default_nettype none

module mep_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                pix_valid,
  output logic                pix_ready,
  input  mep_pkg::dp_status_t status,
  output mep_pkg::dp_cmd_t    cmd
);
  import mep_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (pix_valid) state_next = ST_COORD;
      end
      ST_COORD:  state_next = ST_SQUARE;
      ST_SQUARE: state_next = ST_UPDATE;
      ST_UPDATE: begin
        state_next = status.finish ? ST_FINISH : ST_SQUARE;
      end
      ST_FINISH: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    pix_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        pix_ready   = 1'b1;
        cmd.capture = pix_valid;
      end
      ST_COORD:  cmd.coord  = 1'b1;
      ST_SQUARE: cmd.square = 1'b1;
      ST_UPDATE: cmd.update = !status.finish;
      ST_FINISH: cmd.publish = status.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/mep_datapath.sv
// Datapath: configuration registers, coordinate setup, complex squaring and result register.
`default_nettype none

module mep_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  mep_pkg::cfg_reg_t             cfg_index,
  input  logic [mep_pkg::COORD_W-1:0]   cfg_data,
  input  logic [mep_pkg::INDEX_W-1:0]   row,
  input  logic [mep_pkg::INDEX_W-1:0]   column,
  input  mep_pkg::dp_cmd_t              cmd,
  output mep_pkg::dp_status_t           status,
  input  logic                          res_ready,
  output logic                          res_valid,
  output logic                          res_in_set,
  output logic [mep_pkg::PAL_W-1:0]     res_palette_index,
  output logic [mep_pkg::ITER_W-1:0]    res_iterations
);
  import mep_pkg::*;

  localparam int unsigned PROD_W = INDEX_W + STEP_W;

  logic [COORD_W-1:0] left_edge;
  logic [COORD_W-1:0] top_edge;
  logic [STEP_W-1:0]  column_step;
  logic [STEP_W-1:0]  row_step;
  logic [ITER_W-1:0]  max_iterations;
  logic [SHIFT_W-1:0] color_offset;

  logic [PROD_W-1:0]  prod_col;
  logic [PROD_W-1:0]  prod_row;
  logic signed [COORD_W-1:0] c_re;
  logic signed [COORD_W-1:0] c_im;
  logic signed [COORD_W-1:0] z_re;
  logic signed [COORD_W-1:0] z_im;
  logic [34:0]        sq_re;
  logic [34:0]        sq_im;
  logic [36:0]        cross_term;
  logic [ITER_W-1:0]  count;

  logic signed [63:0] mul_rr;
  logic signed [63:0] mul_ii;
  logic signed [63:0] mul_ri;
  logic [44:0]        re_coord;
  logic [44:0]        im_coord;
  logic [44:0]        re_sum;
  logic [44:0]        im_sum;
  logic [35:0]        mag;
  logic               escaped;
  logic               at_limit;
  logic [ITER_W:0]    pal_sum;
  logic [ITER_W:0]    pal_mod;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_edge      <= LEFT_RESET;
      top_edge       <= TOP_RESET;
      column_step    <= STEP_RESET;
      row_step       <= STEP_RESET;
      max_iterations <= ITER_RESET;
      color_offset   <= SHIFT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_LEFT_EDGE:   left_edge      <= cfg_data;
        CFG_TOP_EDGE:    top_edge       <= cfg_data;
        CFG_COLUMN_STEP: column_step    <= cfg_data[STEP_W-1:0];
        CFG_ROW_STEP:    row_step       <= cfg_data[STEP_W-1:0];
        CFG_MAX_ITER:    max_iterations <= cfg_data[ITER_W-1:0];
        CFG_PAL_SHIFT:   color_offset   <= cfg_data[SHIFT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The point c, exact sum then clamped to 32 bits.
  assign re_coord = {{13{left_edge[31]}}, left_edge} + {2'b00, prod_col};
  assign im_coord = {{13{top_edge[31]}}, top_edge} - {2'b00, prod_row};

  assign mul_rr = z_re * z_re;
  assign mul_ii = z_im * z_im;
  assign mul_ri = z_re * z_im;

  // Squares are non-negative, so bit 63 is zero; shifting keeps floor rounding.
  assign re_sum = {10'd0, sq_re} - {10'd0, sq_im} + {{13{c_re[31]}}, c_re};
  assign im_sum = {{8{cross_term[36]}}, cross_term} + {{13{c_im[31]}}, c_im};

  assign mag      = {1'b0, sq_re} + {1'b0, sq_im};
  assign escaped  = (mag >= ESCAPE_LIMIT);
  assign at_limit = (count >= max_iterations);

  assign status.finish   = (count != '0) && (escaped || at_limit);
  assign status.out_free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      prod_col <= PROD_W'(column) * PROD_W'(column_step);
      prod_row <= PROD_W'(row) * PROD_W'(row_step);
    end
    if (cmd.coord) begin
      c_re  <= sat32(re_coord);
      c_im  <= sat32(im_coord);
      z_re  <= '0;
      z_im  <= '0;
      count <= '0;
    end
    if (cmd.square) begin
      sq_re      <= mul_rr[62:FRAC_BITS];
      sq_im      <= mul_ii[62:FRAC_BITS];
      cross_term <= mul_ri[63:FRAC_BITS-1];
    end
    if (cmd.update) begin
      z_re  <= sat32(re_sum);
      z_im  <= sat32(im_sum);
      count <= count + ITER_W'(1);
    end
  end

  assign pal_sum = {1'b0, count} + (ITER_W+1)'(color_offset);
  assign pal_mod = pal_sum & (ITER_W+1)'(PALETTE_ENTRIES - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.publish) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      res_in_set        <= (count == max_iterations);
      res_palette_index <= (count == max_iterations) ? '0 : pal_mod[PAL_W-1:0];
      res_iterations    <= count;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mandelbrot_escape_time_pixel.sv
// Top level of the escape-time pixel evaluator: controller, datapath and channel wiring.
//
//   channel  dir  beat contents
//   -------  ---  --------------------------------------------
//   cfg      in   index (register number), data (write value)
//   pixel    in   row, column
//   result   out  in_set, palette_index, iterations
//
// A pixel goes from its accepted beat through ST_COORD, then ST_SQUARE and
// ST_UPDATE in turn, then ST_FINISH, where its result is registered; the
// three 32x32 squaring multipliers are used in ST_SQUARE, alternating with
// the add-and-saturate step in ST_UPDATE that forms the next z. The next
// pixel beat is taken only back in ST_IDLE, once that result is registered.
// Reset is synchronous and returns the configuration registers to their defaults.
// The result sits in an output register, so a new pixel beat is taken while
// an earlier result still waits on a stalled sink.
`default_nettype none

module mandelbrot_escape_time_pixel (
  input  logic  clk,
  input  logic  rst,
  mep_cfg_if.sink       cfg,
  mep_pixel_if.sink     pixel,
  mep_result_if.source  result
);
  import mep_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Config writes are always taken; write only while idle, the block does not check.
  assign cfg.ready = 1'b1;

  // The controller only sequences; all arithmetic and data storage live in the datapath.
  mep_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pixel.valid),
    .pix_ready (pixel.ready),
    .status    (status),
    .cmd       (cmd)
  );

  mep_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg.valid && cfg.ready),
    .cfg_index         (cfg_reg_t'(cfg.index)),
    .cfg_data          (cfg.data),
    .row               (pixel.row),
    .column            (pixel.column),
    .cmd               (cmd),
    .status            (status),
    .res_ready         (result.ready),
    .res_valid         (result.valid),
    .res_in_set        (result.in_set),
    .res_palette_index (result.palette_index),
    .res_iterations    (result.iterations)
  );

  // A pixel beat starts the work, so the pixel channel must close right after.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (pixel.valid && pixel.ready) |=> !pixel.ready)
    else $error("pixel channel still ready after a pixel beat");

  // Points in the set always carry palette index zero.
  a_black_index: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.in_set) |-> (result.palette_index == '0))
    else $error("in-set result with nonzero palette index");

  // At least one update of z is done for every pixel.
  a_nonzero_count: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.iterations != '0))
    else $error("result with zero iterations");

endmodule

`default_nettype wire
